@@ rtl/core/thpm_pkg.sv @@
// Shared types, widths and codes of the track hit proximity matcher.
package thpm_pkg;

    localparam int FUNC_W   = 2;
    localparam int CUT_W    = 16;
    localparam int WCUT_W   = 17;
    localparam int CORR_W   = 17;
    localparam int QUAL_W   = 18;
    localparam int COUNT_W  = 5;
    localparam int LIMIT_W  = 8;
    localparam int TOTAL_W  = 8;
    localparam int AGE_W    = 4;
    localparam int DIV_NW   = 34;
    localparam int DIV_DW   = 20;
    localparam int DIV_CW   = 6;
    localparam int SQ_W     = 36;
    localparam int ROOT_W   = 18;
    localparam int SQ_CW    = 5;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [QUAL_W-1:0] QMAX = 18'h3FFFF;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = 8'hFF;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TEST   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NOP    = 2'd3;

    localparam logic [2:0] REG_X_CUT         = 3'd0;
    localparam logic [2:0] REG_Y_CUT         = 3'd1;
    localparam logic [2:0] REG_Z_CUT         = 3'd2;
    localparam logic [2:0] REG_COMPARE_COUNT = 3'd3;
    localparam logic [2:0] REG_COMPARE_LIMIT = 3'd4;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

endpackage

@@ rtl/core/thpm_cell.sv @@
// One ring cell: holds a stored hit, shifts it on, and tests it against the candidate.
module thpm_cell #(
    parameter int CW = 20
) (
    input  logic                      clk,
    input  logic                      shift_en,
    input  logic signed [CW-1:0]      x_in,
    input  logic signed [CW-1:0]      y_in,
    input  logic signed [CW-1:0]      z_in,
    output logic signed [CW-1:0]      x_q,
    output logic signed [CW-1:0]      y_q,
    output logic signed [CW-1:0]      z_q,
    input  logic signed [CW-1:0]      cand_x,
    input  logic signed [CW-1:0]      cand_y,
    input  logic signed [CW-1:0]      cand_z,
    input  logic [thpm_pkg::WCUT_W-1:0] x_cut,
    input  logic [thpm_pkg::WCUT_W-1:0] y_cut,
    input  logic [thpm_pkg::WCUT_W-1:0] z_cut,
    output logic [CW:0]               dx,
    output logic [CW:0]               dy,
    output logic [CW:0]               dz,
    output logic                      in_win
);
    import thpm_pkg::*;

    localparam int CMPW = (CW + 1 > WCUT_W) ? CW + 1 : WCUT_W;

    logic signed [CW-1:0] x_reg, y_reg, z_reg;
    logic signed [CW:0]   sx, sy, sz;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            x_reg <= x_in;
            y_reg <= y_in;
            z_reg <= z_in;
        end
    end

    assign x_q = x_reg;
    assign y_q = y_reg;
    assign z_q = z_reg;

    always_comb
    begin
        sx = {x_reg[CW-1], x_reg} - {cand_x[CW-1], cand_x};
        sy = {y_reg[CW-1], y_reg} - {cand_y[CW-1], cand_y};
        sz = {z_reg[CW-1], z_reg} - {cand_z[CW-1], cand_z};
        dx = sx[CW] ? (CW+1)'(-sx) : (CW+1)'(sx);
        dy = sy[CW] ? (CW+1)'(-sy) : (CW+1)'(sy);
        dz = sz[CW] ? (CW+1)'(-sz) : (CW+1)'(sz);
        in_win = (x_cut != '0) && (y_cut != '0) && (z_cut != '0)
              && (CMPW'(dx) <= CMPW'(x_cut))
              && (CMPW'(dy) <= CMPW'(y_cut))
              && (CMPW'(dz) <= CMPW'(z_cut));
    end

endmodule

@@ rtl/core/thpm_div.sv @@
// Restoring divider, one quotient bit per cycle.
module thpm_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [thpm_pkg::DIV_NW-1:0] num,
    input  logic [thpm_pkg::DIV_DW-1:0] den,
    output logic                        done,
    output logic [thpm_pkg::DIV_NW-1:0] quo
);
    import thpm_pkg::*;

    logic [DIV_NW-1:0] q_reg, q_next;
    logic [DIV_DW:0]   rem_reg, rem_next, rem_sh;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              fits;

    always_comb
    begin
        rem_sh    = {rem_reg[DIV_DW-1:0], q_reg[DIV_NW-1]};
        fits      = rem_sh >= {1'b0, den_reg};
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = num;
            rem_next  = '0;
            cnt_next  = DIV_CW'(DIV_NW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_sh - {1'b0, den_reg} : rem_sh;
            q_next   = {q_reg[DIV_NW-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start)
            den_reg <= den;
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

@@ rtl/core/thpm_sqrt.sv @@
// Truncating integer square root, one root bit per cycle.
module thpm_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [thpm_pkg::SQ_W-1:0]   rad,
    output logic                        done,
    output logic [thpm_pkg::ROOT_W-1:0] root
);
    import thpm_pkg::*;

    logic [SQ_W-1:0]   rad_reg, rad_next;
    logic [ROOT_W+1:0] rem_reg, rem_next, rem_sh, trial;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [SQ_CW-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic              fits;

    always_comb
    begin
        rem_sh    = {rem_reg[ROOT_W-1:0], rad_reg[SQ_W-1:SQ_W-2]};
        trial     = {root_reg, 2'b01};
        fits      = rem_sh >= trial;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = rad;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = SQ_CW'(ROOT_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next  = {rad_reg[SQ_W-3:0], 2'b00};
            rem_next  = fits ? rem_sh - trial : rem_sh;
            root_next = {root_reg[ROOT_W-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

@@ rtl/core/track_hit_proximity_match.sv @@
// Track hit proximity matcher: one track's newest hits held in a shifting row of cells.
// Clear, append and no-op items stay in idle. A refused test goes straight to the
// final state; one with no hit in the windows passes the compare and select states. A
// match uses the shared one-bit-per-cycle divider for three axis corrections, sums the
// squares, takes the root and, unless the denominator is zero, divides for the final
// quotient. A finished test waits while an earlier result is stalled at the output. The
// newest hits, up to the compare count, are compared with the candidate at once; a
// priority encoder picks the newest in-window hit. One item is in work at a time.
module track_hit_proximity_match #(
    parameter int RING_DEPTH = 16,
    parameter int COORD_BITS = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [thpm_pkg::ADDR_W-1:0]   paddr,
    input  logic [thpm_pkg::DATA_W-1:0]   pwdata,
    output logic [thpm_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [thpm_pkg::FUNC_W-1:0]   func,
    input  logic signed [19:0]            hit_x,
    input  logic signed [19:0]            hit_y,
    input  logic signed [19:0]            hit_z,
    input  logic [thpm_pkg::QUAL_W-1:0]   match_quality_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          compared,
    output logic                          survive,
    output logic                          matched,
    output logic [thpm_pkg::AGE_W-1:0]    matched_age,
    output logic [thpm_pkg::QUAL_W-1:0]   match_quality_out
);
    import thpm_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CMP  = 4'd1;
    localparam logic [3:0] ST_SEL  = 4'd2;
    localparam logic [3:0] ST_CLD  = 4'd3;
    localparam logic [3:0] ST_CW   = 4'd4;
    localparam logic [3:0] ST_SQ   = 4'd5;
    localparam logic [3:0] ST_RT   = 4'd6;
    localparam logic [3:0] ST_QD   = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;

    // configuration
    logic [CUT_W-1:0]   x_cut_reg, y_cut_reg, z_cut_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_cut_reg <= 16'd160;
            y_cut_reg <= 16'd160;
            z_cut_reg <= 16'd160;
            count_reg <= 5'd4;
            limit_reg <= 8'd255;
        end
        else if (wr_en)
        begin
            case (paddr[4:2])
                REG_X_CUT:         x_cut_reg <= pwdata[CUT_W-1:0];
                REG_Y_CUT:         y_cut_reg <= pwdata[CUT_W-1:0];
                REG_Z_CUT:         z_cut_reg <= pwdata[CUT_W-1:0];
                REG_COMPARE_COUNT: count_reg <= pwdata[COUNT_W-1:0];
                REG_COMPARE_LIMIT: limit_reg <= pwdata[LIMIT_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_X_CUT:         prdata = DATA_W'(x_cut_reg);
            REG_Y_CUT:         prdata = DATA_W'(y_cut_reg);
            REG_Z_CUT:         prdata = DATA_W'(z_cut_reg);
            REG_COMPARE_COUNT: prdata = DATA_W'(count_reg);
            REG_COMPARE_LIMIT: prdata = DATA_W'(limit_reg);
            default:           prdata = '0;
        endcase
    end

    // input coordinates: low COORD_BITS bits as two's complement
    logic [19+CW:0]       ext_x, ext_y, ext_z;
    logic signed [CW-1:0] in_x, in_y, in_z;

    assign ext_x = {{CW{1'b0}}, hit_x};
    assign ext_y = {{CW{1'b0}}, hit_y};
    assign ext_z = {{CW{1'b0}}, hit_z};
    assign in_x  = ext_x[CW-1:0];
    assign in_y  = ext_y[CW-1:0];
    assign in_z  = ext_z[CW-1:0];

    // control and datapath registers
    logic [3:0]           state_reg, state_next;
    logic [TOTAL_W-1:0]   total_reg, total_next;
    logic [TOTAL_W-1:0]   n_reg, n_next;
    logic [RING_DEPTH-1:0] hits_reg, hits_next;
    logic [AW-1:0]        age_reg, age_next;
    logic [1:0]           ax_reg, ax_next;
    logic signed [CW-1:0] cand_x_reg, cand_y_reg, cand_z_reg;
    logic [WCUT_W-1:0]    xc_reg, yc_reg, zc_reg;
    logic [QUAL_W-1:0]    q_reg;
    logic [CORR_W-1:0]    corr_reg [3];
    logic [SQ_W-1:0]      acc_reg, acc_next;
    logic [DIV_DW-1:0]    den_reg, den_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 cmp_reg, surv_reg, mat_reg;
    logic [AGE_W-1:0]     oage_reg;
    logic [QUAL_W-1:0]    oq_reg;
    logic                 res_cmp_reg, res_surv_reg, res_mat_reg;
    logic [QUAL_W-1:0]    res_q_reg;

    logic                 accept, shift_en;
    logic                 div_start, div_done, sq_start, sq_done;
    logic [DIV_NW-1:0]    div_num, div_quo;
    logic [DIV_DW-1:0]    div_den;
    logic [ROOT_W-1:0]    sq_root;

    // cell row
    logic signed [CW-1:0] cx [RING_DEPTH];
    logic signed [CW-1:0] cy [RING_DEPTH];
    logic signed [CW-1:0] cz [RING_DEPTH];
    logic [CW:0]          dxa [RING_DEPTH];
    logic [CW:0]          dya [RING_DEPTH];
    logic [CW:0]          dza [RING_DEPTH];
    logic [RING_DEPTH-1:0] in_win;

    assign accept   = in_valid && in_ready;
    assign shift_en = accept && (func == FUNC_APPEND);

    for (genvar g = 0; g < RING_DEPTH; g++)
    begin : g_cell
        logic signed [CW-1:0] px, py, pz;
        if (g == 0)
        begin : g_head
            assign px = in_x;
            assign py = in_y;
            assign pz = in_z;
        end
        else
        begin : g_link
            assign px = cx[g-1];
            assign py = cy[g-1];
            assign pz = cz[g-1];
        end
        thpm_cell #(.CW(CW)) u_cell (
            .clk      (clk),
            .shift_en (shift_en),
            .x_in     (px),
            .y_in     (py),
            .z_in     (pz),
            .x_q      (cx[g]),
            .y_q      (cy[g]),
            .z_q      (cz[g]),
            .cand_x   (cand_x_reg),
            .cand_y   (cand_y_reg),
            .cand_z   (cand_z_reg),
            .x_cut    (xc_reg),
            .y_cut    (yc_reg),
            .z_cut    (zc_reg),
            .dx       (dxa[g]),
            .dy       (dya[g]),
            .dz       (dza[g]),
            .in_win   (in_win[g])
        );
    end

    thpm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    thpm_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .rad   (acc_reg),
        .done  (sq_done),
        .root  (sq_root)
    );

    // test setup from the current count
    logic [TOTAL_W-1:0] n_pick;
    logic               dbl;
    always_comb
    begin
        dbl    = total_reg <= TOTAL_W'(count_reg);
        n_pick = dbl ? total_reg : TOTAL_W'(count_reg);
        if (n_pick > TOTAL_W'(RING_DEPTH))
            n_pick = TOTAL_W'(RING_DEPTH);
    end

    // newest in-window hit
    logic [AW-1:0] first_idx;
    always_comb
    begin
        first_idx = '0;
        for (int i = RING_DEPTH - 1; i >= 0; i--)
        begin
            if (hits_reg[i])
                first_idx = AW'(i);
        end
    end

    // distance and window of the selected hit on the current axis
    logic [CW:0]        d_sel;
    logic [WCUT_W-1:0]  cut_sel, gap;
    logic [CORR_W-1:0]  corr_cur;
    logic [2*CORR_W-1:0] sq_prod;
    always_comb
    begin
        case (ax_reg)
            AXIS_X:
            begin
                d_sel   = dxa[age_reg];
                cut_sel = xc_reg;
            end
            AXIS_Y:
            begin
                d_sel   = dya[age_reg];
                cut_sel = yc_reg;
            end
            default:
            begin
                d_sel   = dza[age_reg];
                cut_sel = zc_reg;
            end
        endcase
        gap      = cut_sel - WCUT_W'(d_sel);
        corr_cur = corr_reg[ax_reg];
        sq_prod  = corr_cur * corr_cur;
    end

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        n_next         = n_reg;
        hits_next      = hits_reg;
        age_next       = age_reg;
        ax_next        = ax_reg;
        acc_next       = acc_reg;
        den_next       = den_reg;
        out_valid_next = out_valid_reg;
        div_start      = 1'b0;
        div_num        = '0;
        div_den        = '0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        FUNC_CLEAR:  total_next = '0;
                        FUNC_APPEND:
                        begin
                            if (total_reg != TOTAL_MAX)
                                total_next = total_reg + 1'b1;
                        end
                        FUNC_TEST:
                        begin
                            n_next = n_pick;
                            if (total_reg >= limit_reg)
                                state_next = ST_FIN;
                            else
                                state_next = ST_CMP;
                        end
                        default: ;
                    endcase
                end
            end
            ST_CMP:
            begin
                for (int i = 0; i < RING_DEPTH; i++)
                    hits_next[i] = in_win[i] && (TOTAL_W'(i) < n_reg);
                state_next = ST_SEL;
            end
            ST_SEL:
            begin
                age_next = first_idx;
                ax_next  = AXIS_X;
                acc_next = SQ_W'({q_reg, 16'b0});
                den_next = DIV_DW'(q_reg);
                state_next = (hits_reg != '0) ? ST_CLD : ST_FIN;
            end
            ST_CLD:
            begin
                div_start  = 1'b1;
                div_num    = DIV_NW'({gap, 16'b0});
                div_den    = DIV_DW'(cut_sel);
                state_next = ST_CW;
            end
            ST_CW:
            begin
                if (div_done)
                begin
                    if (ax_reg == AXIS_Z)
                    begin
                        ax_next    = AXIS_X;
                        state_next = ST_SQ;
                    end
                    else
                    begin
                        ax_next    = ax_reg + 1'b1;
                        state_next = ST_CLD;
                    end
                end
            end
            ST_SQ:
            begin
                acc_next = acc_reg + SQ_W'(sq_prod);
                den_next = den_reg + DIV_DW'(corr_cur);
                if (ax_reg == AXIS_Z)
                    state_next = ST_RT;
                else
                    ax_next = ax_reg + 1'b1;
            end
            ST_RT:
            begin
                if (sq_done)
                begin
                    if (den_reg == '0)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        div_num    = DIV_NW'({sq_root, 16'b0});
                        div_den    = den_reg;
                        state_next = ST_QD;
                    end
                end
            end
            ST_QD:
            begin
                if (div_done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // kick the root once the last square is summed
    logic sq_go_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            sq_go_reg     <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            sq_go_reg     <= (state_reg == ST_SQ) && (ax_reg == AXIS_Z);
        end
    end

    assign sq_start = sq_go_reg;

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        hits_reg <= hits_next;
        age_reg  <= age_next;
        ax_reg   <= ax_next;
        acc_reg  <= acc_next;
        den_reg  <= den_next;
        if (accept && (func == FUNC_TEST))
        begin
            cand_x_reg   <= in_x;
            cand_y_reg   <= in_y;
            cand_z_reg   <= in_z;
            q_reg        <= match_quality_in;
            xc_reg       <= dbl ? {x_cut_reg, 1'b0} : {1'b0, x_cut_reg};
            yc_reg       <= {1'b0, y_cut_reg};
            zc_reg       <= dbl ? {z_cut_reg, 1'b0} : {1'b0, z_cut_reg};
            res_cmp_reg  <= total_reg < limit_reg;
            res_surv_reg <= total_reg >= limit_reg;
            res_mat_reg  <= 1'b0;
            res_q_reg    <= match_quality_in;
        end
        if (state_reg == ST_SEL && hits_reg != '0)
        begin
            res_surv_reg <= 1'b1;
            res_mat_reg  <= 1'b1;
        end
        if (state_reg == ST_CW && div_done)
            corr_reg[ax_reg] <= div_quo[CORR_W-1:0];
        if (state_reg == ST_RT && sq_done && den_reg == '0)
            res_q_reg <= '0;
        if (state_reg == ST_QD && div_done)
            res_q_reg <= (div_quo > DIV_NW'(QMAX)) ? QMAX : div_quo[QUAL_W-1:0];
        if (state_reg == ST_FIN && (!out_valid_reg || out_ready))
        begin
            cmp_reg  <= res_cmp_reg;
            surv_reg <= res_surv_reg;
            mat_reg  <= res_mat_reg;
            oage_reg <= res_mat_reg ? AGE_W'(age_reg) : '0;
            oq_reg   <= res_q_reg;
        end
    end

    assign in_ready          = (state_reg == ST_IDLE);
    assign out_valid         = out_valid_reg;
    assign compared          = cmp_reg;
    assign survive           = surv_reg;
    assign matched           = mat_reg;
    assign matched_age       = oage_reg;
    assign match_quality_out = oq_reg;

endmodule

@@ rtl/core/thpm_checker.sv @@
// Port-level checks for the track hit proximity matcher and their bind.
module thpm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        compared,
    input logic                        survive,
    input logic                        matched,
    input logic [thpm_pkg::AGE_W-1:0]  matched_age,
    input logic [thpm_pkg::QUAL_W-1:0] match_quality_out
);
    import thpm_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(match_quality_out)
            && $stable(matched) && $stable(matched_age))
        else $error("result changed while stalled");

    // a new result only comes from an item in work
    a_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result raised while idle");

    // a refused test neither matches nor reports an age
    a_refused: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !compared |-> survive && !matched && matched_age == '0)
        else $error("refused test reports a match");

    // a match always survives, and an age only comes with a match
    a_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (matched || matched_age != '0) |-> survive && matched && compared)
        else $error("match flags inconsistent");

endmodule

bind track_hit_proximity_match thpm_checker u_thpm_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ready          (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .compared          (compared),
    .survive           (survive),
    .matched           (matched),
    .matched_age       (matched_age),
    .match_quality_out (match_quality_out)
);

@@ dv/thpm_checker.sv @@
// Scoreboard for the track hit proximity matcher: snoops config writes, predicts and compares.
module thpm_scoreboard (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [thpm_pkg::ADDR_W-1:0]   paddr,
    input  logic [thpm_pkg::DATA_W-1:0]   pwdata,
    input  logic                          pready,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [thpm_pkg::FUNC_W-1:0]   func,
    input  logic signed [19:0]            hit_x,
    input  logic signed [19:0]            hit_y,
    input  logic signed [19:0]            hit_z,
    input  logic [thpm_pkg::QUAL_W-1:0]   match_quality_in,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          compared,
    input  logic                          survive,
    input  logic                          matched,
    input  logic [thpm_pkg::AGE_W-1:0]    matched_age,
    input  logic [thpm_pkg::QUAL_W-1:0]   match_quality_out,
    output int                            fail_count,
    output int                            pending,
    output int                            n_tests,
    output int                            n_matched,
    output int                            n_refused
);
    import thpm_pkg::*;

    localparam int DEPTH = 16;

    typedef struct packed {
        logic              compared;
        logic              survive;
        logic              matched;
        logic [AGE_W-1:0]  age;
        logic [QUAL_W-1:0] quality;
    } verdict_t;

    verdict_t expected_verdicts[$];

    longint            ring_x[DEPTH];
    longint            ring_y[DEPTH];
    longint            ring_z[DEPTH];
    int unsigned       total;
    int unsigned       head;
    logic [CUT_W-1:0]  cut_x, cut_y, cut_z;
    logic [COUNT_W-1:0] cmp_count;
    logic [LIMIT_W-1:0] cmp_limit;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // Returns 1 inside the window, corr in Q1.16.
    function automatic bit in_window(longint a, longint b, longint unsigned cut,
                                     output longint unsigned corr);
        longint unsigned d;
        d = (a >= b) ? longint'(a - b) : longint'(b - a);
        corr = 0;
        if (cut == 0 || d > cut)
            return 0;
        corr = ((cut - d) << 16) / cut;
        return 1;
    endfunction

    function automatic verdict_t test_hit(longint hx, longint hy, longint hz,
                                          longint unsigned q);
        verdict_t v;
        int unsigned n, idx;
        longint unsigned scale, cx, cy, cz, num, den, root, qual;
        bit ix, iy, iz;
        v.compared = 1'b1;
        v.survive  = 1'b0;
        v.matched  = 1'b0;
        v.age      = '0;
        v.quality  = q[QUAL_W-1:0];
        if (total >= cmp_limit)
        begin
            v.compared = 1'b0;
            v.survive  = 1'b1;
            return v;
        end
        n = total;
        scale = 2;
        if (n > cmp_count)
        begin
            n = cmp_count;
            scale = 1;
        end
        if (n > DEPTH)
            n = DEPTH;
        for (int i = 0; i < n; i++)
        begin
            idx = (head + DEPTH - 1 - i) % DEPTH;
            ix = in_window(ring_x[idx], hx, scale * cut_x, cx);
            iy = in_window(ring_y[idx], hy, longint'(cut_y), cy);
            iz = in_window(ring_z[idx], hz, scale * cut_z, cz);
            if (ix && iy && iz)
            begin
                num = cx * cx + cy * cy + cz * cz + (q << 16);
                den = cx + cy + cz + q;
                root = int_sqrt(num);
                qual = 0;
                if (den != 0)
                begin
                    qual = (root << 16) / den;
                    if (qual > QMAX)
                        qual = QMAX;
                end
                v.survive = 1'b1;
                v.matched = 1'b1;
                v.age     = i[AGE_W-1:0];
                v.quality = qual[QUAL_W-1:0];
                return v;
            end
        end
        return v;
    endfunction

    assign pending = expected_verdicts.size();

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t exp_v, got_v;
        if (!rst_n)
        begin
            expected_verdicts.delete();
            total     = 0;
            head      = 0;
            cut_x     = 16'd160;
            cut_y     = 16'd160;
            cut_z     = 16'd160;
            cmp_count = 5'd4;
            cmp_limit = 8'd255;
            fail_count = 0;
            n_tests   = 0;
            n_matched = 0;
            n_refused = 0;
        end
        else
        begin
            // results first: they belong to items accepted earlier
            if (out_valid && out_ready)
            begin
                got_v = '{compared, survive, matched, matched_age, match_quality_out};
                if (expected_verdicts.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transfer: %p", got_v);
                end
                else
                begin
                    exp_v = expected_verdicts.pop_front();
                    if (got_v !== exp_v)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result mismatch: expected %p, got %p", exp_v, got_v);
                    end
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_X_CUT:         cut_x     = pwdata[CUT_W-1:0];
                    REG_Y_CUT:         cut_y     = pwdata[CUT_W-1:0];
                    REG_Z_CUT:         cut_z     = pwdata[CUT_W-1:0];
                    REG_COMPARE_COUNT: cmp_count = pwdata[COUNT_W-1:0];
                    REG_COMPARE_LIMIT: cmp_limit = pwdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                case (func)
                    FUNC_CLEAR:
                    begin
                        total = 0;
                        head  = 0;
                    end
                    FUNC_APPEND:
                    begin
                        ring_x[head] = hit_x;
                        ring_y[head] = hit_y;
                        ring_z[head] = hit_z;
                        head = (head + 1) % DEPTH;
                        if (total < 255)
                            total++;
                    end
                    FUNC_TEST:
                    begin
                        exp_v = test_hit(hit_x, hit_y, hit_z, match_quality_in);
                        n_tests++;
                        if (exp_v.matched)
                            n_matched++;
                        if (!exp_v.compared)
                            n_refused++;
                        expected_verdicts.push_back(exp_v);
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

@@ dv/tb_track_hit_proximity_match.sv @@
// Stimulus and verdict for the track hit proximity matcher.
module tb_track_hit_proximity_match;
    import thpm_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int SETTLE      = 250;

    logic                clk;
    logic                rst_n;
    logic                psel, penable, pwrite, pready;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata, prdata;
    logic                in_valid, in_ready;
    logic [FUNC_W-1:0]   func;
    logic signed [19:0]  hit_x, hit_y, hit_z;
    logic [QUAL_W-1:0]   match_quality_in;
    logic                out_valid, out_ready;
    logic                compared, survive, matched;
    logic [AGE_W-1:0]    matched_age;
    logic [QUAL_W-1:0]   match_quality_out;

    int fail_count, pending, n_tests, n_matched, n_refused;
    int cycles;
    int burst_left;
    int sent;
    int win_x, win_y, win_z;
    int recent_x[$], recent_y[$], recent_z[$];

    track_hit_proximity_match u_dut (.*);

    thpm_scoreboard u_checker (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: out_ready follows one of four stall modes, redrawn at random periodically
    int stall_mode, stall_cnt;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_mode <= 0;
            stall_cnt  <= 0;
        end
        else
        begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt % 96 == 0)
                stall_mode <= $urandom_range(0, 3);
            case (stall_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= $urandom_range(0, 1);
                2:       out_ready <= (stall_cnt % 9) < 3;
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    task automatic reg_write(logic [2:0] idx, int unsigned val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // hold valid until the transfer, then maybe open a gap
    task automatic send(logic [FUNC_W-1:0] f, int x, int y, int z, int unsigned q);
        int gap;
        in_valid         <= 1'b1;
        func             <= f;
        hit_x            <= x[19:0];
        hit_y            <= y[19:0];
        hit_z            <= z[19:0];
        match_quality_in <= q[QUAL_W-1:0];
        do
            @(posedge clk);
        while (!in_ready);
        sent++;
        if (f == FUNC_APPEND)
        begin
            recent_x.push_front(x);
            recent_y.push_front(y);
            recent_z.push_front(z);
            if (recent_x.size() > 16)
            begin
                void'(recent_x.pop_back());
                void'(recent_y.pop_back());
                void'(recent_z.pop_back());
            end
        end
        if (f == FUNC_CLEAR)
        begin
            recent_x.delete();
            recent_y.delete();
            recent_z.delete();
        end
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic configure(int cx, int cy, int cz, int cnt, int lim);
        drain();
        reg_write(REG_X_CUT, cx);
        reg_write(REG_Y_CUT, cy);
        reg_write(REG_Z_CUT, cz);
        reg_write(REG_COMPARE_COUNT, cnt);
        reg_write(REG_COMPARE_LIMIT, lim);
        win_x = cx;
        win_y = cy;
        win_z = cz;
    endtask

    function automatic int rand_coord();
        if ($urandom_range(0, 3) == 0)
            return $urandom();
        return $urandom_range(0, 4000) - 2000;
    endfunction

    function automatic int rand_qual();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 262143);
            1:       return 0;
            default: return $urandom_range(0, 70000);
        endcase
    endfunction

    function automatic int jitter(int w);
        int s;
        s = 2 * w + 2;
        return $urandom_range(0, 2 * s) - s;
    endfunction

    // tracks: an optional clear, a run of appends, then tests mostly near stored hits and rare no-ops
    task automatic run_tracks(int items);
        int target, k, m, pick;
        target = sent + items;
        while (sent < target)
        begin
            if ($urandom_range(0, 2) != 0)
                send(FUNC_CLEAR, rand_coord(), rand_coord(), rand_coord(), rand_qual());
            k = $urandom_range(0, 20);
            repeat (k)
                send(FUNC_APPEND, rand_coord(), rand_coord(), rand_coord(), rand_qual());
            m = $urandom_range(1, 6);
            repeat (m)
            begin
                if (recent_x.size() > 0 && $urandom_range(0, 9) < 7)
                begin
                    pick = $urandom_range(0, (recent_x.size() < 6 ? recent_x.size() : 6) - 1);
                    send(FUNC_TEST, recent_x[pick] + jitter(win_x),
                         recent_y[pick] + jitter(win_y) / 2,
                         recent_z[pick] + jitter(win_z), rand_qual());
                end
                else if ($urandom_range(0, 9) == 0)
                    send(FUNC_NOP, rand_coord(), rand_coord(), rand_coord(), rand_qual());
                else
                    send(FUNC_TEST, rand_coord(), rand_coord(), rand_coord(), rand_qual());
            end
        end
    endtask

    initial
    begin
        sent       = 0;
        burst_left = 8;
        win_x = 160;
        win_y = 160;
        win_z = 160;
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        func     = FUNC_NOP;
        hit_x    = '0;
        hit_y    = '0;
        hit_z    = '0;
        match_quality_in = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty track, window edges, zero denominator, saturation, extremes
        send(FUNC_CLEAR, 0, 0, 0, 0);
        send(FUNC_TEST, 0, 0, 0, 7);
        send(FUNC_APPEND, 0, 0, 0, 0);
        send(FUNC_TEST, 0, 0, 0, 0);
        send(FUNC_TEST, 320, 160, -320, 0);
        send(FUNC_TEST, -320, -160, 320, 1);
        send(FUNC_TEST, 321, 0, 0, 5);
        send(FUNC_TEST, 0, 161, 0, 5);
        send(FUNC_TEST, 0, 0, -321, 5);
        send(FUNC_NOP, -1, -1, -1, 262143);
        send(FUNC_APPEND, 524287, -524288, 524287, 0);
        send(FUNC_APPEND, -524288, 524287, -524288, 0);
        send(FUNC_TEST, -524288, 524287, -524288, 262143);
        send(FUNC_TEST, 524287, -524288, 524287, 262143);
        send(FUNC_TEST, 100, -100, 50, 131072);
        send(FUNC_TEST, 524287, 524287, 524287, 65536);
        send(FUNC_APPEND, 5, 5, 5, 0);
        send(FUNC_APPEND, 10, 10, 10, 0);
        send(FUNC_TEST, 0, 0, 0, 100);

        run_tracks(120);

        // saturate the hit count, then tests are refused at the default limit
        send(FUNC_CLEAR, 0, 0, 0, 0);
        repeat (260)
            send(FUNC_APPEND, rand_coord(), rand_coord(), rand_coord(), 0);
        repeat (4)
            send(FUNC_TEST, recent_x[0], recent_y[0], recent_z[0], rand_qual());

        configure(65535, 65535, 65535, 16, 255);
        run_tracks(90);
        configure(1, 1, 1, 0, 1);
        run_tracks(60);
        configure(1, 65535, 1, 16, 3);
        run_tracks(60);
        configure(40, 40, 40, 2, 12);
        run_tracks(60);
        configure($urandom_range(1, 65535), $urandom_range(1, 65535),
                  $urandom_range(1, 65535), $urandom_range(0, 16), $urandom_range(1, 255));
        run_tracks(60);
        configure($urandom_range(8, 3000), $urandom_range(8, 3000),
                  $urandom_range(8, 3000), $urandom_range(0, 16), $urandom_range(5, 40));
        run_tracks(60);
        drain();

        $display("%0d items sent; %0d tests checked, %0d matched, %0d refused",
                 sent, n_tests, n_matched, n_refused);
        $display("covered six window/count/limit settings including both extremes");
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
